// ===== hdl/iir_pkg.sv =====
// Shared types and constants for the direct-form I IIR filter.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package iir_pkg;
    localparam logic [2:0] CMD_STEP     = 3'd0;
    localparam logic [2:0] CMD_WR_NUM   = 3'd1;
    localparam logic [2:0] CMD_WR_DEN   = 3'd2;
    localparam logic [2:0] CMD_RST_IN   = 3'd3;
    localparam logic [2:0] CMD_RST_OUT  = 3'd4;
    localparam logic signed [31:0] COEFF_ONE = 32'sh0040_0000;
    localparam int ACC_W = 64;
    localparam int DIV_W = 56;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,     // clear accumulator and sums
        OP_MAC,       // one coefficient product into the accumulator
        OP_SUM,       // one coefficient into the numerator/denominator sums
        OP_STEP_END,  // round, saturate, shift histories
        OP_WRITE,     // coefficient write
        OP_DIV_LOAD,  // load divider operands from the sums
        OP_DIV_ITER,  // one restoring division step
        OP_FILL       // fill histories from the quotient
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] tap;   // coefficient / history position
        logic       den;   // denominator side selected
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== hdl/iir_ctrl.sv =====
// Controller state machine for the IIR filter: sequences the shared MAC,
// sum and divider steps. Depends on iir_pkg.
`default_nettype none
module iir_ctrl
    import iir_pkg::*;
#(
    parameter int MAX_ORDER = 10
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] command,
    input  wire logic [3:0] order,
    input  wire dp_stat_t   stat,
    output dp_cmd_t         cmd,
    output logic            res_valid,
    input  wire logic       res_ready
);
    localparam int TW = 5;
    typedef enum logic [2:0] {S_IDLE, S_MAC, S_SUM, S_DIV, S_FIN, S_OUT} state_t;

    state_t      state_reg, state_next;
    logic [TW-1:0] k_reg, k_next;
    logic        den_reg, den_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic        res_valid_reg, res_valid_next;
    logic [TW-1:0] n;

    assign n = ({1'b0, order} > TW'(MAX_ORDER)) ? TW'(MAX_ORDER) : {1'b0, order};
    assign in_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;

    // Next-state and command decode
    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        den_next = den_reg;
        cmd_next = cmd_reg;
        res_valid_next = res_valid_reg && !res_ready;
        cmd = '{op: OP_NONE, tap: k_reg, den: den_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd_next = command;
                    k_next = '0;
                    den_next = 1'b0;
                    cmd.op = OP_CLEAR;
                    case (command) inside
                        CMD_STEP: state_next = S_MAC;
                        CMD_RST_IN, CMD_RST_OUT: state_next = S_SUM;
                        CMD_WR_NUM, CMD_WR_DEN:
                        begin
                            cmd.op = OP_WRITE;
                            res_valid_next = 1'b1;
                        end
                        default: res_valid_next = 1'b1;
                    endcase
                end
            end
            S_MAC:
            begin
                // b0*u, then b[k]*x[k-1] and a[k]*y[k-1] alternately
                cmd.op = OP_MAC;
                if (k_reg == n && (den_reg || k_reg == '0))
                    state_next = S_FIN;
                else if (k_reg == '0 || den_reg)
                begin
                    k_next = k_reg + 1'b1;
                    den_next = 1'b0;
                end
                else
                    den_next = 1'b1;
            end
            S_SUM:
            begin
                cmd.op = OP_SUM;
                if (k_reg == n)
                begin
                    cmd.op = OP_SUM;
                    state_next = S_DIV;
                    k_next = '0;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            S_DIV:
            begin
                // load once, then iterate until the divider reports done
                cmd.op = (k_reg == '0) ? OP_DIV_LOAD : OP_DIV_ITER;
                k_next = TW'(1);
                if (stat.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op = (cmd_reg == CMD_STEP) ? OP_STEP_END : OP_FILL;
                state_next = S_OUT;
                res_valid_next = 1'b1;
            end
            S_OUT:
                if (!res_valid_reg || res_ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg <= '0;
            den_reg <= 1'b0;
            cmd_reg <= CMD_STEP;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            den_reg <= den_next;
            cmd_reg <= cmd_next;
            res_valid_reg <= res_valid_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/iir_dp.sv =====
// Datapath for the IIR filter: coefficient and history registers, the
// shared multiply-accumulate, sums and a restoring divider. Depends on iir_pkg.
`default_nettype none
module iir_dp
    import iir_pkg::*;
#(
    parameter int MAX_ORDER = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    output dp_stat_t                stat,
    input  wire logic               in_accept,
    input  wire logic [2:0]         command,
    input  wire logic signed [15:0] sample_value,
    input  wire logic [3:0]         coeff_index,
    input  wire logic signed [31:0] coeff_value,
    output logic signed [15:0]      result_value,
    output logic                    saturated
);
    localparam int DEPTH = MAX_ORDER + 1;
    localparam int IW = $clog2(DEPTH);

    logic signed [31:0] num_reg [DEPTH];
    logic signed [31:0] den_reg [DEPTH];
    logic signed [15:0] xh_reg [DEPTH];
    logic signed [15:0] yh_reg [DEPTH];

    logic [2:0]         cmd_reg;
    logic signed [15:0] v_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [39:0] ns_reg, ds_reg;
    logic signed [15:0] res_reg;
    logic               sat_reg;

    // divider: |n| / |d|, restoring, one quotient bit per cycle
    logic [DIV_W-1:0] dq_reg, dr_reg, dd_reg;
    logic [5:0]       dcnt_reg;
    logic             dneg_reg;

    logic [IW-1:0] ti;
    logic signed [31:0] mc;
    logic signed [15:0] mh;
    logic signed [47:0] prod;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] q;
    logic unity;
    logic [DIV_W-1:0] trial;
    logic signed [55:0] num_op;
    logic signed [39:0] den_op;

    assign ti = cmd.tap[IW-1:0];
    assign unity = (ds_reg > -40'sd4) && (ds_reg < 40'sd4);

    // Select MAC operands: b0*u at tap 0, else history one behind
    always_comb
    begin
        if (cmd.tap == '0)
        begin
            mc = num_reg[0];
            mh = v_reg;
        end
        else if (cmd.den)
        begin
            mc = den_reg[ti];
            mh = yh_reg[ti - 1'b1];
        end
        else
        begin
            mc = num_reg[ti];
            mh = xh_reg[ti - 1'b1];
        end
        prod = 48'(mc) * 48'(mh);
        rnd = (acc_reg + 64'sd2097152) >>> 22;
        q = dneg_reg ? -$signed({8'd0, dq_reg}) : $signed({8'd0, dq_reg});
        trial = {dr_reg[DIV_W-2:0], dq_reg[DIV_W-1]};
        if (cmd_reg == CMD_RST_IN)
        begin
            num_op = 56'(v_reg) * 56'(ns_reg);
            den_op = ds_reg;
        end
        else
        begin
            num_op = 56'(v_reg) * 56'(ds_reg);
            den_op = ns_reg;
        end
    end

    assign stat.div_done = (dcnt_reg == 6'(DIV_W));
    assign result_value = res_reg;
    assign saturated = sat_reg;

    // Capture request fields and run the datapath operations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                num_reg[i] <= (i == 0) ? COEFF_ONE : '0;
                den_reg[i] <= (i == 0) ? COEFF_ONE : '0;
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
            dcnt_reg <= '0;
            res_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                cmd_reg <= command;
                v_reg <= sample_value;
                res_reg <= '0;
                sat_reg <= 1'b0;
                if ((command == CMD_WR_NUM) && ({1'b0, coeff_index} <= 5'(MAX_ORDER)))
                    num_reg[IW'(coeff_index)] <= coeff_value;
                if ((command == CMD_WR_DEN) && ({1'b0, coeff_index} <= 5'(MAX_ORDER)))
                    den_reg[IW'(coeff_index)] <= coeff_value;
            end
            case (cmd.op)
                OP_CLEAR:
                begin
                    acc_reg <= '0;
                    ns_reg <= '0;
                    ds_reg <= 40'(COEFF_ONE);
                    dcnt_reg <= '0;
                end
                OP_MAC:
                    if (cmd.den)
                        acc_reg <= acc_reg - ACC_W'(prod);
                    else
                        acc_reg <= acc_reg + ACC_W'(prod);
                OP_SUM:
                begin
                    ns_reg <= ns_reg + 40'(num_reg[ti]);
                    if (cmd.tap != '0)
                        ds_reg <= ds_reg + 40'(den_reg[ti]);
                end
                OP_DIV_LOAD:
                begin
                    dneg_reg <= (num_op < 0) != (den_op < 0);
                    dd_reg <= DIV_W'(den_op < 0 ? -den_op : den_op);
                    dq_reg <= DIV_W'(num_op < 0 ? -num_op : num_op)
                              + (DIV_W'(den_op < 0 ? -den_op : den_op) >> 1);
                    dr_reg <= '0;
                    dcnt_reg <= '0;
                end
                OP_DIV_ITER:
                    if (dcnt_reg != 6'(DIV_W))
                    begin
                        dcnt_reg <= dcnt_reg + 1'b1;
                        if (trial >= dd_reg)
                        begin
                            dr_reg <= trial - dd_reg;
                            dq_reg <= {dq_reg[DIV_W-2:0], 1'b1};
                        end
                        else
                        begin
                            dr_reg <= trial;
                            dq_reg <= {dq_reg[DIV_W-2:0], 1'b0};
                        end
                    end
                OP_STEP_END:
                begin
                    if (rnd > 64'sd32767)
                    begin
                        res_reg <= 16'sh7fff;
                        sat_reg <= 1'b1;
                        yh_reg[0] <= 16'sh7fff;
                    end
                    else if (rnd < -64'sd32768)
                    begin
                        res_reg <= -16'sh8000;
                        sat_reg <= 1'b1;
                        yh_reg[0] <= -16'sh8000;
                    end
                    else
                    begin
                        res_reg <= 16'(rnd);
                        sat_reg <= 1'b0;
                        yh_reg[0] <= 16'(rnd);
                    end
                    xh_reg[0] <= v_reg;
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        xh_reg[i] <= xh_reg[i-1];
                        yh_reg[i] <= yh_reg[i-1];
                    end
                end
                OP_FILL:
                begin : fill_blk
                    logic signed [15:0] f;
                    logic c;
                    f = v_reg;
                    c = 1'b0;
                    if (!unity)
                    begin
                        if (cmd_reg == CMD_RST_OUT && ns_reg == '0)
                        begin
                            c = (v_reg != '0);
                            f = (v_reg > 0) ? 16'sh7fff :
                                (v_reg < 0) ? -16'sh8000 : '0;
                        end
                        else if (q > 64'sd32767)
                        begin
                            f = 16'sh7fff;
                            c = 1'b1;
                        end
                        else if (q < -64'sd32768)
                        begin
                            f = -16'sh8000;
                            c = 1'b1;
                        end
                        else
                            f = 16'(q);
                    end
                    sat_reg <= c;
                    res_reg <= (cmd_reg == CMD_RST_IN) ? f : v_reg;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        xh_reg[i] <= (cmd_reg == CMD_RST_IN) ? v_reg : f;
                        yh_reg[i] <= (cmd_reg == CMD_RST_IN) ? f : v_reg;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/iir_direct_form_filter.sv =====
// Top level of the direct-form I IIR filter: order register, controller and
// datapath. Depends on iir_pkg, iir_ctrl and iir_dp.
//
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, command..coeff_value   | request in
//  out     | out_valid/out_ready, result_value, saturated | result out
//  cfg     | cfg_valid/cfg_ready, cfg_data             | order register write
//
// A sample step runs its products through the one shared multiplier; a
// reset command forms the sums and then runs the bit-serial divider.
// One request is in flight; the next is taken once its result is taken.
// rst_n zeroes the order, histories and coefficients, except b0 = a0 = unity.
`default_nettype none
module iir_direct_form_filter
    import iir_pkg::*;
#(
    parameter int MAX_ORDER = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         command,
    input  wire logic signed [15:0] sample_value,
    input  wire logic [3:0]         coeff_index,
    input  wire logic signed [31:0] coeff_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      result_value,
    output logic                    saturated,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_data
);
    logic [3:0] order_reg;
    dp_cmd_t    cmd;
    dp_stat_t   stat;

    assign cfg_ready = 1'b1;

    // Hold the order register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= '0;
        else if (cfg_valid)
            order_reg <= cfg_data;
    end

    iir_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .command,
        .order(order_reg), .stat, .cmd,
        .res_valid(out_valid), .res_ready(out_ready)
    );

    iir_dp #(.MAX_ORDER(MAX_ORDER)) u_dp (
        .clk, .rst_n, .cmd, .stat,
        .in_accept(in_valid && in_ready), .command, .sample_value,
        .coeff_index, .coeff_value, .result_value, .saturated
    );
endmodule
`default_nettype wire

// ===== hdl/iir_checker.sv =====
// Port-level checker for the IIR filter and its bind to the top level.
// Depends on iir_direct_form_filter's ports only.
`default_nettype none
module iir_port_checks (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] result_value,
    input wire logic        saturated
);
    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(saturated))
        else $error("result changed while stalled");
    // No request taken while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken with result pending");
    // Drop ready after a request is taken
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready not dropped after request");
    // A presented result carries known bits
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({result_value, saturated}))
        else $error("unknown result bits");
endmodule

bind iir_direct_form_filter iir_port_checks u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .result_value, .saturated
);
`default_nettype wire

// ===== tb/iir_checker.sv =====
// Checker for the direct-form I IIR filter: watches the request, result and
// order-register channels, predicts each result and compares it field by field.
// Depends on iir_pkg for the command codes and the unity coefficient.
`timescale 1ns / 100ps
module iir_checker
    import iir_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [2:0]         command,
    input  wire logic signed [15:0] sample_value,
    input  wire logic [3:0]         coeff_index,
    input  wire logic signed [31:0] coeff_value,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [15:0] result_value,
    input  wire logic               saturated,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [3:0]         cfg_data,
    output int                      error_count,
    output int                      pending,
    output int                      result_count
);
    localparam int TAPS_MAX = 10;
    localparam int FIFO_DEPTH = 64;

    typedef struct packed {
        logic signed [15:0] value;
        logic               clip;
    } filter_out_t;

    logic signed [31:0] num_coeff [0:TAPS_MAX];
    logic signed [31:0] den_coeff [0:TAPS_MAX];
    logic signed [15:0] x_hist [0:TAPS_MAX];
    logic signed [15:0] y_hist [0:TAPS_MAX];
    logic [3:0]         order_reg;
    filter_out_t        expected_results [FIFO_DEPTH];
    int                 wr_count = 0;
    int                 rd_count = 0;

    function automatic logic signed [15:0] clip16(input longint v, inout logic flag);
        if (v > 32767) begin
            flag = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768) begin
            flag = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Quotient rounded to nearest, halves away from zero
    function automatic longint div_round_away(input longint n, input longint d);
        longint un;
        longint ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (un + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic void fill_history(input logic signed [15:0] x,
                                         input logic signed [15:0] y);
        for (int k = 0; k <= TAPS_MAX; k++) begin
            x_hist[k] = x;
            y_hist[k] = y;
        end
    endfunction

    // Advance the filter state by one request and return its result
    function automatic filter_out_t filter_response(input logic [2:0] cmd,
                                                    input logic signed [15:0] v,
                                                    input logic [3:0] idx,
                                                    input logic signed [31:0] c);
        filter_out_t r;
        int          n;
        longint      acc;
        longint      ns;
        longint      ds;
        logic        unity;
        r = '0;
        n = (order_reg > TAPS_MAX) ? TAPS_MAX : order_reg;
        case (cmd)
            CMD_STEP: begin
                acc = longint'(num_coeff[0]) * v;
                for (int k = 1; k <= n; k++) begin
                    acc += longint'(num_coeff[k]) * x_hist[k-1];
                    acc -= longint'(den_coeff[k]) * y_hist[k-1];
                end
                r.value = clip16((acc + 64'sd2097152) >>> 22, r.clip);
                for (int k = TAPS_MAX; k > 0; k--) begin
                    x_hist[k] = x_hist[k-1];
                    y_hist[k] = y_hist[k-1];
                end
                x_hist[0] = v;
                y_hist[0] = r.value;
            end
            CMD_WR_NUM, CMD_WR_DEN: begin
                if (idx <= TAPS_MAX) begin
                    if (cmd == CMD_WR_NUM) num_coeff[idx] = c;
                    else den_coeff[idx] = c;
                end
            end
            CMD_RST_IN, CMD_RST_OUT: begin
                ns = 0;
                ds = longint'(COEFF_ONE);
                for (int k = 0; k <= n; k++) ns += num_coeff[k];
                for (int k = 1; k <= n; k++) ds += den_coeff[k];
                unity = (ds > -4 && ds < 4);
                if (cmd == CMD_RST_IN) begin
                    r.value = unity ? v : clip16(div_round_away(v * ns, ds), r.clip);
                    fill_history(v, r.value);
                end else begin
                    logic signed [15:0] x;
                    if (unity) x = v;
                    else if (ns == 0) begin
                        x = (v > 0) ? 16'sh7fff : (v < 0) ? 16'sh8000 : 16'sh0000;
                        r.clip = (v != 0);
                    end else x = clip16(div_round_away(v * ds, ns), r.clip);
                    fill_history(x, v);
                    r.value = v;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    assign pending = wr_count - rd_count;

    always @(posedge clk or negedge rst_n)
    begin
        filter_out_t e;
        if (!rst_n)
        begin
            for (int k = 0; k <= TAPS_MAX; k++)
            begin
                num_coeff[k] = '0;
                den_coeff[k] = '0;
                x_hist[k] = '0;
                y_hist[k] = '0;
            end
            num_coeff[0] = COEFF_ONE;
            den_coeff[0] = COEFF_ONE;
            order_reg = '0;
            wr_count = 0;
            rd_count = 0;
            error_count = 0;
            result_count = 0;
        end
        else
        begin
            // track the order register
            if (cfg_valid && cfg_ready) order_reg = cfg_data;
            // predict each accepted request
            if (in_valid && in_ready)
            begin
                expected_results[wr_count % FIFO_DEPTH] =
                    filter_response(command, sample_value, coeff_index, coeff_value);
                wr_count++;
            end
            // compare each accepted result with the oldest prediction
            if (out_valid && out_ready)
            begin
                result_count++;
                if (wr_count == rd_count)
                    report_mismatch("results outstanding", 0, 1);
                else
                begin
                    e = expected_results[rd_count % FIFO_DEPTH];
                    rd_count++;
                    if (result_value !== e.value)
                        report_mismatch("result_value", result_value, e.value);
                    if (saturated !== e.clip)
                        report_mismatch("saturated", saturated, e.clip);
                end
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Top of the IIR filter testbench: clock, reset, request and order-register
// stimulus, and the verdict. Depends on iir_pkg, iir_direct_form_filter, iir_checker.
`timescale 1ns / 100ps
module testbench
    import iir_pkg::*;
();

    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;
    localparam logic signed [31:0] COEFF_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] COEFF_MIN = 32'sh8000_0000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         command = '0;
    logic signed [15:0] sample_value = '0;
    logic [3:0]         coeff_index = '0;
    logic signed [31:0] coeff_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] result_value;
    logic               saturated;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_data = '0;
    int                 error_count;
    int                 pending;
    int                 result_count;
    int                 gap_pct = 0;
    int                 stall_pct = 0;
    int                 requests_sent = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    iir_direct_form_filter dut (.*);

    iir_checker u_checker (.*);

    // Stall the result channel at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Send one request after an optional random gap
    task automatic send_request(input logic [2:0] cmd, input logic signed [15:0] v,
                                input logic [3:0] idx, input logic signed [31:0] c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        sample_value <= v;
        coeff_index  <= idx;
        coeff_value  <= c;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Write the order register once the filter is idle
    task automatic write_order(input logic [3:0] order);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= order;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coeff();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? COEFF_MAX : COEFF_MIN;
            default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1:       return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            send_request(CMD_STEP, rand_sample(), 4'($urandom), 32'($urandom));
        else if (pick < 82)
            send_request($urandom_range(1) ? CMD_WR_NUM : CMD_WR_DEN, 16'($urandom),
                         ($urandom_range(9) == 0) ? 4'($urandom_range(15, 11))
                                                  : 4'($urandom_range(10)),
                         rand_coeff());
        else if (pick < 96)
            send_request($urandom_range(1) ? CMD_RST_IN : CMD_RST_OUT, rand_sample(),
                         4'($urandom), 32'($urandom));
        else
            send_request(3'($urandom_range(CMD_BAD_HI, CMD_BAD_LO)), 16'($urandom),
                         4'($urandom), 32'($urandom));
    endtask

    initial
    begin
        logic [3:0] orders [7];
        orders = '{4'd3, 4'd10, 4'd15, 4'd1, 4'd11, 4'd5, 4'd0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every command, special cases
        write_order(4'd1);
        send_request(CMD_STEP, 16'sh7fff, 4'd0, 32'sd0);
        send_request(CMD_STEP, 16'sh8000, 4'd0, 32'sd0);
        send_request(CMD_WR_NUM, 16'sd0, 4'd0, COEFF_MAX);
        send_request(CMD_STEP, 16'sh7fff, 4'd0, 32'sd0);
        send_request(CMD_STEP, 16'sh8000, 4'd0, 32'sd0);
        send_request(CMD_WR_NUM, 16'sd0, 4'd0, COEFF_MIN);
        send_request(CMD_STEP, 16'sh8000, 4'd0, 32'sd0);
        send_request(CMD_WR_NUM, 16'sd0, 4'd0, 32'sh0040_0000);
        send_request(CMD_WR_NUM, 16'sd0, 4'd1, 32'sh0020_0000);
        send_request(CMD_WR_DEN, 16'sd0, 4'd0, 32'sd12345);
        send_request(CMD_WR_DEN, 16'sd0, 4'd1, 32'shffe0_0000);
        send_request(CMD_RST_IN, 16'sd20000, 4'd0, 32'sd0);
        send_request(CMD_STEP, 16'sd1000, 4'd0, 32'sd0);
        send_request(CMD_RST_OUT, 16'sh8000, 4'd0, 32'sd0);
        // near-zero denominator sum gives unity gain
        send_request(CMD_WR_DEN, 16'sd0, 4'd1, 32'shffc0_0002);
        send_request(CMD_RST_IN, 16'sd777, 4'd0, 32'sd0);
        send_request(CMD_RST_OUT, -16'sd555, 4'd0, 32'sd0);
        // zero numerator sum on reset to output
        send_request(CMD_WR_DEN, 16'sd0, 4'd1, 32'sd0);
        send_request(CMD_WR_NUM, 16'sd0, 4'd1, 32'shffc0_0000);
        send_request(CMD_RST_OUT, 16'sd300, 4'd0, 32'sd0);
        send_request(CMD_RST_OUT, 16'sd0, 4'd0, 32'sd0);
        // ignored index and unknown commands
        send_request(CMD_WR_NUM, 16'sd0, 4'd15, COEFF_MAX);
        send_request(CMD_WR_DEN, 16'sd0, 4'd11, COEFF_MIN);
        send_request(CMD_BAD_LO, 16'sh7fff, 4'd15, COEFF_MIN);
        send_request(CMD_BAD_HI, 16'sh8000, 4'd5, COEFF_MAX);

        // Random phases over several orders and idling modes
        foreach (orders[p])
        begin
            write_order(orders[p]);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 67; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 67; end
                default: begin gap_pct = 31; stall_pct = 31; end
            endcase
            for (int i = 0; i < 118; i++)
            begin
                random_request();
                // hold off once until every result is back
                if (p == 2 && i == 50) wait_drained();
            end
        end

        wait_drained();
        repeat (100) @(posedge clk);
        $display("Covered %0d requests and %0d results over orders 0..15,",
                 requests_sent, result_count);
        $display("with steps, coefficient writes, both resets and unknown commands.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timed out with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end
endmodule
